// File: hw/rtl/tlnc_pkg.sv
package tlnc_pkg;

    // line counter geometry
    localparam int CountDigits = 6;
    localparam int CountW      = 4 * CountDigits;
    localparam int DigitIdxW   = (CountDigits > 1) ? $clog2(CountDigits) : 1;

    // output sequence of one item: digits, tab, up to three prefix bytes, final byte
    localparam int StepTab   = CountDigits;
    localparam int StepFinal = CountDigits + 4;
    localparam int StepW     = $clog2(StepFinal + 1);

    // decoupling queue
    localparam int QueueDepth = 4;
    localparam int QPtrW      = $clog2(QueueDepth);
    localparam int QCountW    = $clog2(QueueDepth + 1);

    // configuration register indexes
    localparam int CfgAddrW = 3;
    localparam logic [CfgAddrW-1:0] CfgNumberAll      = 3'd0;
    localparam logic [CfgAddrW-1:0] CfgNumberNonblank = 3'd1;
    localparam logic [CfgAddrW-1:0] CfgShowNonprint   = 3'd2;
    localparam logic [CfgAddrW-1:0] CfgShowEnds       = 3'd3;
    localparam logic [CfgAddrW-1:0] CfgSqueezeBlank   = 3'd4;
    localparam logic [CfgAddrW-1:0] CfgShowTabs       = 3'd5;

    // characters
    localparam logic [7:0] ChTab     = 8'h09;
    localparam logic [7:0] ChNewline = 8'h0A;
    localparam logic [7:0] ChSpace   = 8'h20;
    localparam logic [7:0] ChDollar  = 8'h24;
    localparam logic [7:0] ChDash    = 8'h2D;
    localparam logic [7:0] ChZero    = 8'h30;
    localparam logic [7:0] ChQuest   = 8'h3F;
    localparam logic [7:0] ChI       = 8'h49;
    localparam logic [7:0] ChM       = 8'h4D;
    localparam logic [7:0] ChCaret   = 8'h5E;

    // prefix placed before the final byte
    typedef enum logic [2:0] {
        PRE_NONE,
        PRE_DOLLAR,
        PRE_CARET,
        PRE_META,
        PRE_META_CARET
    } tlnc_pre_t;

    // one classified item handed from front to back
    typedef struct packed {
        logic                num_en;
        logic [CountW-1:0]   count;
        tlnc_pre_t           pre;
        logic [7:0]          final_byte;
    } tlnc_job_t;

endpackage

// File: hw/rtl/tlnc_front.sv
module tlnc_front
    import tlnc_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [7:0]          s_tdata,
    input  logic                s_tuser,
    input  logic                cfg_we,
    input  logic [CfgAddrW-1:0] cfg_addr,
    input  logic                cfg_wdata,
    input  logic                q_full,
    output logic                push,
    output tlnc_job_t           push_job
);

    typedef enum logic [1:0] {
        BLANK_NONE,
        BLANK_ONE,
        BLANK_RUN
    } blank_t;

    // saturating bcd increment
    function automatic logic [CountW-1:0] bcd_inc(input logic [CountW-1:0] c);
        logic [CountW-1:0] r;
        logic              carry;
        logic              full;
        r     = c;
        carry = 1'b1;
        full  = 1'b1;
        for (int i = 0; i < CountDigits; i++) begin
            if (c[4*i +: 4] != 4'd9) full = 1'b0;
        end
        for (int i = 0; i < CountDigits; i++) begin
            if (carry) begin
                if (r[4*i +: 4] < 4'd9) begin
                    r[4*i +: 4] = r[4*i +: 4] + 4'd1;
                    carry       = 1'b0;
                end else begin
                    r[4*i +: 4] = 4'd0;
                end
            end
        end
        return full ? c : r;
    endfunction

    logic              number_all_reg, number_nonblank_reg, show_np_reg;
    logic              show_ends_reg, squeeze_reg, show_tabs_reg;
    logic [CountW-1:0] count_reg, count_next;
    logic              prev_nl_reg;
    blank_t            blank_reg, blank_next;

    logic       accept;
    logic       line_start;
    logic       is_nl;
    logic       dropped;
    logic       num_en;
    logic [6:0] low7;
    logic       ctrl;
    tlnc_pre_t  pre;
    logic [7:0] final_byte;

    assign s_tready   = !q_full;
    assign accept     = s_tvalid && !q_full;
    assign line_start = prev_nl_reg || s_tuser;
    assign is_nl      = (s_tdata == ChNewline);

    // blank line tracking and numbering decision
    always_comb
    begin
        blank_next = blank_reg;
        if (line_start && squeeze_reg) begin
            if (is_nl) begin
                blank_next = (blank_reg == BLANK_NONE) ? BLANK_ONE : BLANK_RUN;
            end else begin
                blank_next = BLANK_NONE;
            end
        end
        dropped    = line_start && squeeze_reg && (blank_next == BLANK_RUN);
        num_en     = line_start && !dropped &&
                     (number_nonblank_reg ? !is_nl : number_all_reg);
        count_next = num_en ? bcd_inc(count_reg) : count_reg;
    end

    // escape classification
    always_comb
    begin
        low7       = s_tdata[6:0];
        ctrl       = (low7 <= 7'd31) || (low7 == 7'd127);
        pre        = PRE_NONE;
        final_byte = s_tdata;
        if (is_nl) begin
            if (show_ends_reg) pre = PRE_DOLLAR;
        end else if (s_tdata == ChTab) begin
            if (show_tabs_reg) begin
                pre        = PRE_CARET;
                final_byte = ChI;
            end
        end else if (show_np_reg) begin
            if (s_tdata[7]) begin
                pre = ctrl ? PRE_META_CARET : PRE_META;
            end else begin
                pre = ctrl ? PRE_CARET : PRE_NONE;
            end
            if (ctrl) begin
                final_byte = (low7 == 7'd127) ? ChQuest : {1'b0, low7 | 7'd64};
            end else begin
                final_byte = {1'b0, low7};
            end
        end
    end

    assign push                = accept && !dropped;
    assign push_job.num_en     = num_en;
    assign push_job.count      = count_next;
    assign push_job.pre        = pre;
    assign push_job.final_byte = final_byte;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            number_all_reg      <= 1'b0;
            number_nonblank_reg <= 1'b0;
            show_np_reg         <= 1'b0;
            show_ends_reg       <= 1'b0;
            squeeze_reg         <= 1'b0;
            show_tabs_reg       <= 1'b0;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                CfgNumberAll:      number_all_reg      <= cfg_wdata;
                CfgNumberNonblank: number_nonblank_reg <= cfg_wdata;
                CfgShowNonprint:   show_np_reg         <= cfg_wdata;
                CfgShowEnds:       show_ends_reg       <= cfg_wdata;
                CfgSqueezeBlank:   squeeze_reg         <= cfg_wdata;
                CfgShowTabs:       show_tabs_reg       <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // line state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            count_reg   <= '0;
            prev_nl_reg <= 1'b1;
            blank_reg   <= BLANK_NONE;
        end else if (accept) begin
            count_reg   <= count_next;
            prev_nl_reg <= is_nl;
            blank_reg   <= blank_next;
        end
    end

endmodule

// File: hw/rtl/tlnc_queue.sv
module tlnc_queue
    import tlnc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  tlnc_job_t push_job,
    output logic      full,
    input  logic      pop,
    output logic      head_valid,
    output tlnc_job_t head
);

    tlnc_job_t          slots_reg [QueueDepth];
    logic [QPtrW-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [QCountW-1:0] fill_reg;

    assign full       = (fill_reg == QCountW'(QueueDepth));
    assign head_valid = (fill_reg != '0);
    assign head       = slots_reg[rd_ptr_reg];

    // pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            if (push) wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)  rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (push && !pop) begin
                fill_reg <= fill_reg + 1'b1;
            end else if (pop && !push) begin
                fill_reg <= fill_reg - 1'b1;
            end
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (push) slots_reg[wr_ptr_reg] <= push_job;
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && full))
        else $error("queue written while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head_valid)
        else $error("queue popped while empty");

endmodule

// File: hw/rtl/tlnc_back.sv
module tlnc_back
    import tlnc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       job_valid,
    input  tlnc_job_t  job,
    output logic       pop,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,
    output logic       m_tlast
);

    function automatic logic [1:0] pre_len(input tlnc_pre_t p);
        logic [1:0] r;
        case (p)
            PRE_DOLLAR, PRE_CARET: r = 2'd1;
            PRE_META:              r = 2'd2;
            PRE_META_CARET:        r = 2'd3;
            default:               r = 2'd0;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] pre_char(input tlnc_pre_t p, input logic [1:0] j);
        logic [7:0] r;
        case (p)
            PRE_DOLLAR: r = ChDollar;
            PRE_CARET:  r = ChCaret;
            default:    r = (j == 2'd0) ? ChM : ((j == 2'd1) ? ChDash : ChCaret);
        endcase
        return r;
    endfunction

    logic             active_reg, active_next;
    logic [StepW-1:0] step_reg, step_next;
    logic             out_valid_reg;
    logic [7:0]       out_data_reg, out_data_next;
    logic             out_last_reg;

    logic                 load;
    logic [StepW-1:0]     pre_start;
    logic [StepW-1:0]     cur_step;
    logic [DigitIdxW-1:0] k;
    logic [CountW-1:0]    upper;
    logic [3:0]           digit;
    logic [1:0]           j;
    logic                 is_final;

    assign load      = job_valid && (!out_valid_reg || m_tready);
    assign pre_start = StepW'(StepFinal) - StepW'(pre_len(job.pre));
    assign cur_step  = active_reg ? step_reg : (job.num_en ? '0 : pre_start);
    assign is_final  = (cur_step == StepW'(StepFinal));
    assign pop       = load && is_final;

    // byte for the current step
    always_comb
    begin
        k     = DigitIdxW'(CountDigits - 1) - cur_step[DigitIdxW-1:0];
        upper = job.count >> {k, 2'b00};
        digit = job.count[4*k +: 4];
        j     = 2'(cur_step - pre_start);
        if (cur_step < StepW'(StepTab)) begin
            out_data_next = ((upper == '0) && (k != '0)) ? ChSpace : (ChZero | {4'd0, digit});
        end else if (cur_step == StepW'(StepTab)) begin
            out_data_next = ChTab;
        end else if (!is_final) begin
            out_data_next = pre_char(job.pre, j);
        end else begin
            out_data_next = job.final_byte;
        end
    end

    // step sequencing
    always_comb
    begin
        active_next = active_reg;
        step_next   = step_reg;
        if (load) begin
            active_next = !is_final;
            step_next   = (cur_step == StepW'(StepTab)) ? pre_start : cur_step + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            active_reg    <= 1'b0;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            active_reg <= active_next;
            step_reg   <= step_next;
            if (load) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // output register payload
    always_ff @(posedge clk)
    begin
        if (load) begin
            out_data_reg <= out_data_next;
            out_last_reg <= is_final;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

    a_active_has_job: assert property (@(posedge clk) disable iff (!rst_n)
        active_reg |-> job_valid)
        else $error("sequencer active without a queued job");

    a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
        active_reg |-> (step_reg <= StepW'(StepFinal)))
        else $error("step beyond final byte");

    a_last_pops: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> (m_tvalid && m_tlast))
        else $error("job popped without a last word");

endmodule

// File: hw/rtl/text_line_number_and_caret_escape.sv
// Text line numbering and caret escape stage.
// Input stream (s_*): one raw text byte per word; s_tuser marks the first
// byte of a new file, which then starts a line. Output stream (m_*): the
// transformed bytes; m_tlast marks the final byte caused by one input word.
// A dropped (squeezed) blank line produces no output words.
// Configuration: cfg_we with cfg_addr selects one of six option bits
// (number all, number nonblank, show nonprinting, show ends, squeeze blank,
// show tabs); bit 0 of cfg_wdata is stored. Write only while idle.
// An accepted word goes into a queue slot, then from the queue head into the
// output register. Throughput: a front stage classifies one input word per
// cycle into a four-entry queue; the back sequencer emits one output byte per
// cycle while the receiver is ready; a kept input word yields 1 to 11 bytes
// (number prefix of six digits and a tab, up to three escape bytes, final
// byte). Input is taken one word per cycle while the queue has room.
// Reset: options clear, line count goes to zero, next byte starts a line.
// When the receiver stalls, the output register holds its word, the queue
// fills, and s_tready drops once four items are waiting.
module text_line_number_and_caret_escape
    import tlnc_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [7:0]          s_tdata,   // [7:0] in_byte
    input  logic                s_tuser,   // [0] file_start
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [7:0]          m_tdata,   // [7:0] out_byte
    output logic                m_tlast,
    input  logic                cfg_we,
    input  logic [CfgAddrW-1:0] cfg_addr,
    input  logic                cfg_wdata
);

    logic      q_full;
    logic      push;
    tlnc_job_t push_job;
    logic      pop;
    logic      head_valid;
    tlnc_job_t head;

    // classify input words and keep line state
    tlnc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .q_full    (q_full),
        .push      (push),
        .push_job  (push_job)
    );

    // decoupling queue
    tlnc_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_job   (push_job),
        .full       (q_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head       (head)
    );

    // expand each job into output bytes
    tlnc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (head_valid),
        .job       (head),
        .pop       (pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

endmodule

// File: verif/text_line_number_and_caret_escape_checker.sv
module text_line_number_and_caret_escape_checker
    import tlnc_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    input  logic                s_tready,
    input  logic [7:0]          s_tdata,   // [7:0] in_byte
    input  logic                s_tuser,   // [0] file_start
    input  logic                m_tvalid,
    input  logic                m_tready,
    input  logic [7:0]          m_tdata,   // [7:0] out_byte
    input  logic                m_tlast,
    input  logic                cfg_we,
    input  logic [CfgAddrW-1:0] cfg_addr,
    input  logic                cfg_wdata,
    output int                  failures,
    output int                  outstanding,
    output int                  words_in,
    output int                  words_out,
    output int                  prefixes
);

    localparam logic [7:0] CtrlMax     = 8'd31;
    localparam logic [7:0] DelChar     = 8'd127;
    localparam logic [7:0] CaretOffset = 8'd64;
    localparam logic [CountW-1:0] CountFull = {CountDigits{4'd9}};

    // one expected output word
    typedef struct packed {
        logic [7:0] ch;
        logic       ends_item;
    } out_char_t;

    out_char_t char_q[$];
    out_char_t want;

    // option bits as the block should hold them
    logic opt_all;
    logic opt_nonblank;
    logic opt_nonprint;
    logic opt_ends;
    logic opt_squeeze;
    logic opt_tabs;

    // text state
    logic [CountW-1:0] line_bcd;
    logic              at_line_start;
    logic [1:0]        blank_run;

    int nfail;
    int nin;
    int nout;
    int nprefix;

    task automatic push_char(input logic [7:0] ch, input logic ends_item);
        out_char_t c;
        c.ch = ch;
        c.ends_item = ends_item;
        char_q.push_back(c);
    endtask

    // bump the bcd line counter, saturating, then emit six digits and a tab
    task automatic push_line_number();
        logic       lead;
        logic [3:0] d;
        lead = 1'b1;
        if (line_bcd != CountFull)
        begin
            for (int i = 0; i < CountDigits; i++)
            begin
                if (line_bcd[4*i +: 4] == 4'd9)
                    line_bcd[4*i +: 4] = 4'd0;
                else
                begin
                    line_bcd[4*i +: 4] = line_bcd[4*i +: 4] + 4'd1;
                    break;
                end
            end
        end
        for (int i = CountDigits - 1; i >= 0; i--)
        begin
            d = line_bcd[4*i +: 4];
            if (d != 4'd0 || i == 0)
                lead = 1'b0;
            push_char(lead ? ChSpace : ChZero + {4'd0, d}, 1'b0);
        end
        push_char(ChTab, 1'b0);
        nprefix++;
    endtask

    // expected output run of one input byte
    task automatic expand_byte(input logic [7:0] raw, input logic new_file);
        logic [7:0] b;
        logic       starts;
        logic       is_nl;
        logic       drop;
        b = raw;
        starts = at_line_start || new_file;
        is_nl = (raw == ChNewline);
        drop = 1'b0;
        if (starts)
        begin
            if (opt_squeeze)
                blank_run = is_nl ? ((blank_run == 2'd0) ? 2'd1 : 2'd2) : 2'd0;
            drop = opt_squeeze && blank_run == 2'd2;
            if (!drop && (opt_nonblank ? !is_nl : opt_all))
                push_line_number();
        end
        at_line_start = is_nl;
        if (!drop)
        begin
            if (is_nl)
            begin
                if (opt_ends)
                    push_char(ChDollar, 1'b0);
            end
            else if (raw == ChTab)
            begin
                if (opt_tabs)
                begin
                    push_char(ChCaret, 1'b0);
                    b = ChI;
                end
            end
            else if (opt_nonprint)
            begin
                if (b[7])
                begin
                    push_char(ChM, 1'b0);
                    push_char(ChDash, 1'b0);
                    b[7] = 1'b0;
                end
                if (b <= CtrlMax || b == DelChar)
                begin
                    push_char(ChCaret, 1'b0);
                    b = (b == DelChar) ? ChQuest : b + CaretOffset;
                end
            end
            push_char(b, 1'b1);
        end
    endtask

    // watch the channels, predict and compare
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            char_q.delete();
            opt_all       = 1'b0;
            opt_nonblank  = 1'b0;
            opt_nonprint  = 1'b0;
            opt_ends      = 1'b0;
            opt_squeeze   = 1'b0;
            opt_tabs      = 1'b0;
            line_bcd      = '0;
            at_line_start = 1'b1;
            blank_run     = 2'd0;
            nfail         = 0;
            nin           = 0;
            nout          = 0;
            nprefix       = 0;
        end
        else
        begin
            // option writes
            if (cfg_we)
            begin
                case (cfg_addr)
                    CfgNumberAll:      opt_all      = cfg_wdata;
                    CfgNumberNonblank: opt_nonblank = cfg_wdata;
                    CfgShowNonprint:   opt_nonprint = cfg_wdata;
                    CfgShowEnds:       opt_ends     = cfg_wdata;
                    CfgSqueezeBlank:   opt_squeeze  = cfg_wdata;
                    CfgShowTabs:       opt_tabs     = cfg_wdata;
                    default:           ;
                endcase
            end

            // accepted input word
            if (s_tvalid && s_tready)
            begin
                expand_byte(s_tdata, s_tuser);
                nin++;
            end

            // accepted output word against the oldest expectation
            if (m_tvalid && m_tready)
            begin
                nout++;
                if (char_q.size() == 0)
                begin
                    $error("out_byte: expected nothing, got %02h", m_tdata);
                    nfail++;
                end
                else
                begin
                    want = char_q.pop_front();
                    if (m_tdata !== want.ch)
                    begin
                        $error("out_byte: expected %02h, got %02h", want.ch, m_tdata);
                        nfail++;
                    end
                    if (m_tlast !== want.ends_item)
                    begin
                        $error("last: expected %0b, got %0b", want.ends_item, m_tlast);
                        nfail++;
                    end
                end
            end
        end
        failures    <= nfail;
        outstanding <= char_q.size();
        words_in    <= nin;
        words_out   <= nout;
        prefixes    <= nprefix;
    end

endmodule

// File: verif/tb_text_line_number_and_caret_escape.sv
module tb_text_line_number_and_caret_escape;
    import tlnc_pkg::*;

    localparam int RandPhases    = 5;
    localparam int PhaseItems    = 16;
    localparam int DrainCycles   = 20;
    localparam int LongHold      = 60;
    localparam logic [CfgAddrW-1:0] CfgSpareLo = CfgShowTabs + 1'b1;
    localparam logic [CfgAddrW-1:0] CfgSpareHi = '1;

    logic                clk = 1'b0;
    logic                rst_n;
    logic                s_tvalid;
    logic                s_tready;
    logic [7:0]          s_tdata;   // [7:0] in_byte
    logic                s_tuser;   // [0] file_start
    logic                m_tvalid;
    logic                m_tready;
    logic [7:0]          m_tdata;   // [7:0] out_byte
    logic                m_tlast;
    logic                cfg_we;
    logic [CfgAddrW-1:0] cfg_addr;
    logic                cfg_wdata;

    int failures;
    int outstanding;
    int words_in;
    int words_out;
    int prefixes;
    int settings;

    // shared between the sender and the receiver
    bit quiet;
    bit long_hold_req;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    text_line_number_and_caret_escape uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    text_line_number_and_caret_escape_checker chk (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .cfg_we      (cfg_we),
        .cfg_addr    (cfg_addr),
        .cfg_wdata   (cfg_wdata),
        .failures    (failures),
        .outstanding (outstanding),
        .words_in    (words_in),
        .words_out   (words_out),
        .prefixes    (prefixes)
    );

    task automatic write_reg(input logic [CfgAddrW-1:0] addr, input logic value);
        cfg_we    <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= value;
        @(posedge clk);
    endtask

    task automatic set_options(input logic n_all, input logic n_nonblank,
                               input logic nonprint, input logic ends,
                               input logic squeeze, input logic tabs);
        write_reg(CfgNumberAll, n_all);
        write_reg(CfgNumberNonblank, n_nonblank);
        write_reg(CfgShowNonprint, nonprint);
        write_reg(CfgShowEnds, ends);
        write_reg(CfgSqueezeBlank, squeeze);
        write_reg(CfgShowTabs, tabs);
        cfg_we <= 1'b0;
        settings++;
    endtask

    // offer one word after a random gap, return once it is taken
    task automatic send_word(input logic [7:0] b, input logic new_file);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 7);
        if (gap != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= new_file;
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    // wait until every expected word is out, then let the block settle
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (DrainCycles) @(posedge clk);
    endtask

    function automatic logic [7:0] pick_char();
        case ($urandom_range(0, 9))
            0:       return ChTab;
            1:       return 8'($urandom_range(0, 31));
            2:       return 8'($urandom_range(128, 255));
            3:       return 8'h7F;
            4:       return 8'($urandom_range(0, 255));
            default: return 8'($urandom_range(32, 126));
        endcase
    endfunction

    // short lines with random content, runs of blank lines, stray file starts
    task automatic random_text(input int target);
        int sent;
        int len;
        int nls;
        sent = 0;
        while (sent < target)
        begin
            len = $urandom_range(0, 4);
            for (int j = 0; j < len; j++)
            begin
                send_word(pick_char(), $urandom_range(0, 11) == 0);
                sent++;
            end
            nls = ($urandom_range(0, 3) == 0) ? $urandom_range(2, 4) : 1;
            for (int j = 0; j < nls; j++)
            begin
                send_word(ChNewline, $urandom_range(0, 15) == 0);
                sent++;
            end
        end
    endtask

    // receiver: random stalls per word, one long hold-off on request
    initial
    begin
        int stall;
        m_tready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                m_tready <= 1'b0;
                repeat (LongHold) @(posedge clk);
            end
            else
            begin
                stall = quiet ? 0 : $urandom_range(0, 7);
                if (stall != 0)
                begin
                    m_tready <= 1'b0;
                    repeat (stall) @(posedge clk);
                end
            end
            m_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_tvalid);
        end
    end

    // stimulus and verdict
    initial
    begin
        rst_n     <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_addr  <= '0;
        cfg_wdata <= 1'b0;
        quiet     = 1'b0;
        settings  = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // escapes, blank squeeze with every line numbered
        set_options(1'b1, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1);
        send_word(ChNewline, 1'b0);
        send_word(ChNewline, 1'b0);
        send_word(ChNewline, 1'b0);
        send_word(8'h00, 1'b0);
        send_word(8'h1F, 1'b0);
        send_word(8'h7F, 1'b0);
        send_word(8'h80, 1'b0);
        send_word(8'hFF, 1'b0);
        send_word(8'h89, 1'b0);
        send_word(8'h8A, 1'b0);
        send_word(ChTab, 1'b0);
        send_word(ChSpace, 1'b0);
        send_word(8'h7E, 1'b0);
        send_word(ChNewline, 1'b0);
        send_word(8'h62, 1'b0);
        send_word(8'h63, 1'b1);
        send_word(ChNewline, 1'b0);
        send_word(ChNewline, 1'b0);
        send_word(ChNewline, 1'b0);
        drain();

        // squeeze off with the blank run left high, nonblank numbering wins
        write_reg(CfgSpareLo, 1'b1);
        write_reg(CfgSpareHi, 1'b1);
        set_options(1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0);
        send_word(ChNewline, 1'b0);
        send_word(ChNewline, 1'b0);
        send_word(ChTab, 1'b0);
        send_word(8'h89, 1'b0);
        send_word(8'h7F, 1'b0);
        send_word(ChNewline, 1'b0);
        send_word(8'h00, 1'b1);
        send_word(ChNewline, 1'b1);
        drain();

        // random text under several option settings
        for (int p = 0; p < RandPhases; p++)
        begin
            case (p)
                0:       set_options(1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1);
                1:       set_options(1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
                2:       set_options(1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1);
                default: set_options($urandom_range(0, 1), $urandom_range(0, 1),
                                     $urandom_range(0, 1), $urandom_range(0, 1),
                                     $urandom_range(0, 1), $urandom_range(0, 1));
            endcase
            if (p == 2)
            begin
                // back up the output so the input side has to stall
                quiet = 1'b1;
                long_hold_req = 1'b1;
            end
            else
                quiet = ($urandom_range(0, 3) == 0);
            random_text(PhaseItems);
            drain();
        end

        $display("covered %0d input words and %0d output words over %0d option settings,",
                 words_in, words_out, settings);
        $display("with %0d line number prefixes and one long output stall", prefixes);
        if (failures == 0)
            $display("[text_line_number_and_caret_escape] OK");
        else
            $display("[text_line_number_and_caret_escape] ERROR");
        $finish;
    end

    // watchdog
    initial
    begin
        #3000000;
        $display("[text_line_number_and_caret_escape] ERROR");
        $finish;
    end

endmodule

// File: text_line_number_and_caret_escape.f
hw/rtl/tlnc_pkg.sv
hw/rtl/tlnc_front.sv
hw/rtl/tlnc_queue.sv
hw/rtl/tlnc_back.sv
hw/rtl/text_line_number_and_caret_escape.sv
verif/text_line_number_and_caret_escape_checker.sv
verif/tb_text_line_number_and_caret_escape.sv
